/* src/sac_pkg.sv */
// shared constants and helpers for the set-associative cache tag model
package sac_pkg;

  // register map, word index on the configuration port
  localparam logic [1:0] RegOffsetBits = 2'd0;
  localparam logic [1:0] RegSetBits    = 2'd1;
  localparam logic [1:0] RegWays       = 2'd2;
  localparam logic [1:0] RegLruMode    = 2'd3;

  // reset values of the configuration registers
  localparam logic [5:0] OffsetBitsRst = 6'd6;
  localparam logic [3:0] SetBitsRst    = 4'd0;
  localparam logic [3:0] WaysRst       = 4'd1;
  localparam logic       LruModeRst    = 1'b0;

  // index width for a store of the given depth, never below one bit
  function automatic int addr_w(input int depth);
    int w;
    w = $clog2(depth);
    return (w < 1) ? 1 : w;
  endfunction

  // largest b with 2**b <= n
  function automatic int floor_log2(input int n);
    int b;
    b = 0;
    while ((b < 31) && ((64'd1 << (b + 1)) <= 64'(n))) b++;
    return b;
  endfunction

endpackage

/* src/sac_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [sac_pkg::addr_w(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                  wdata_i,
  input  logic                              re_i,
  input  logic [sac_pkg::addr_w(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]                  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/set_assoc_cache_tag_model.sv */
// top level of the set-associative cache tag store with hit, miss and traffic counters
//
//  channel   direction  tdata / data                         tuser / control
//  s_axis    in         address (47:0)                       func (0 read, 1 write)
//  m_axis    out        reads, hits, writes, misses (32 each) hit
//  apb       in/out     offset_bits, set_bits, ways, lru_mode at 0x0, 0x4, 0x8, 0xc
//
//  each access first reads the whole set row from the tag ram, then compares all ways,
//  writes the reordered row back and counts
//  the row valid flops clear at reset, so no clearing pass is needed
//  a result that is not taken holds the compare/write cycle until the output register frees
//  a new access is taken while the previous result still waits in the output register
module set_assoc_cache_tag_model #(
  parameter int MAX_SETS    = 256,
  parameter int MAX_WAYS    = 8,
  parameter int ADDR_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream: tdata = address[47:0]; tuser = func
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,
  input  logic         s_axis_tuser,
  // master stream: tdata = memory_reads, hit_count, memory_writes, miss_count; tuser = hit
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,
  output logic         m_axis_tuser,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int EffW    = (ADDR_WIDTH < 48) ? ADDR_WIDTH : 48;
  localparam int SetMax  = sac_pkg::floor_log2(MAX_SETS);
  localparam int IdxW    = sac_pkg::addr_w(MAX_SETS);
  localparam int WayW    = sac_pkg::addr_w(MAX_WAYS);
  localparam int WcntW   = $clog2(MAX_WAYS + 1);
  localparam int RowW    = MAX_WAYS * (EffW + 1);

  typedef struct packed {
    logic            v;
    logic [EffW-1:0] tag;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } state_e;

  // configuration registers
  logic [5:0] offset_bits_q;
  logic [3:0] set_bits_q;
  logic [3:0] ways_q;
  logic       lru_mode_q;

  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= sac_pkg::OffsetBitsRst;
      set_bits_q    <= sac_pkg::SetBitsRst;
      ways_q        <= sac_pkg::WaysRst;
      lru_mode_q    <= sac_pkg::LruModeRst;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        sac_pkg::RegOffsetBits: offset_bits_q <= pwdata[5:0];
        sac_pkg::RegSetBits:    set_bits_q    <= pwdata[3:0];
        sac_pkg::RegWays:       ways_q        <= pwdata[3:0];
        sac_pkg::RegLruMode:    lru_mode_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sac_pkg::RegOffsetBits: prdata = {26'd0, offset_bits_q};
      sac_pkg::RegSetBits:    prdata = {28'd0, set_bits_q};
      sac_pkg::RegWays:       prdata = {28'd0, ways_q};
      sac_pkg::RegLruMode:    prdata = {31'd0, lru_mode_q};
      default:                prdata = '0;
    endcase
  end

  // address split, done in the accept cycle
  logic [EffW-1:0] addr_eff;
  logic [4:0]      sb_sat;
  logic [6:0]      tag_shift;
  logic [EffW-1:0] addr_sh;
  logic [IdxW-1:0] set_raw;
  logic [IdxW-1:0] set_idx;
  logic [EffW-1:0] tag_in;

  assign addr_eff  = s_axis_tdata[EffW-1:0];
  assign sb_sat    = (5'(set_bits_q) > 5'(SetMax)) ? 5'(SetMax) : 5'(set_bits_q);
  assign tag_shift = 7'(offset_bits_q) + 7'(sb_sat);
  assign addr_sh   = addr_eff >> offset_bits_q;
  assign set_raw   = addr_sh[IdxW-1:0] & ~({IdxW{1'b1}} << sb_sat);
  assign set_idx   = (32'(set_raw) >= 32'(MAX_SETS)) ? '0 : set_raw;
  // a shift past the address width leaves a zero tag
  assign tag_in    = addr_eff >> tag_shift;

  state_e          state_q;
  logic [IdxW-1:0] set_q;
  logic [EffW-1:0] tag_q;
  logic            func_q;
  logic [MAX_SETS-1:0] row_valid_q;

  logic s_xfer;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  // tag ram, one row per set holding every way
  logic [RowW-1:0] rd_row;
  logic [RowW-1:0] wr_row;
  logic            ram_we;

  sac_ram #(
    .WIDTH (RowW),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (wr_row),
    .re_i    (s_xfer),
    .raddr_i (set_idx),
    .rdata_o (rd_row)
  );

  // compare and reorder
  row_t            old_row;
  row_t            new_row;
  logic [WcntW-1:0] w_use;
  logic            hit;
  logic [WayW-1:0] hit_way;
  logic [WayW-1:0] shift_lim;
  logic            row_upd;
  logic            out_free;
  logic            commit;

  always_comb begin
    // a row never written since reset reads as all invalid
    old_row = row_valid_q[set_q] ? row_t'(rd_row) : '0;
    if (ways_q == 4'd0) begin
      w_use = WcntW'(1);
    end else if (32'(ways_q) > 32'(MAX_WAYS)) begin
      w_use = WcntW'(MAX_WAYS);
    end else begin
      w_use = WcntW'(ways_q);
    end

    hit     = 1'b0;
    hit_way = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if ((32'(i) < 32'(w_use)) && old_row[i].v && (old_row[i].tag == tag_q)) begin
        hit     = 1'b1;
        hit_way = WayW'(i);
      end
    end

    shift_lim = hit ? hit_way : WayW'(w_use - WcntW'(1));
    new_row   = old_row;
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (32'(i) <= 32'(shift_lim)) begin
        new_row[i] = old_row[i-1];
      end
    end
    new_row[0].v   = 1'b1;
    new_row[0].tag = tag_q;
  end

  assign wr_row   = RowW'(new_row);
  assign row_upd  = !hit || lru_mode_q;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign commit   = (state_q == ST_LOOK) && out_free;
  assign ram_we   = commit && row_upd;

  // memory reads equal misses, so one counter serves both
  logic [COUNT_WIDTH-1:0] miss_cnt_q, miss_cnt_d;
  logic [COUNT_WIDTH-1:0] hit_cnt_q, hit_cnt_d;
  logic [COUNT_WIDTH-1:0] wr_cnt_q, wr_cnt_d;

  assign miss_cnt_d = hit ? miss_cnt_q : miss_cnt_q + COUNT_WIDTH'(1);
  assign hit_cnt_d  = hit ? hit_cnt_q + COUNT_WIDTH'(1) : hit_cnt_q;
  assign wr_cnt_d   = func_q ? wr_cnt_q + COUNT_WIDTH'(1) : wr_cnt_q;

  logic         m_valid_q;
  logic         m_hit_q;
  logic [127:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_valid_q <= '0;
      miss_cnt_q  <= '0;
      hit_cnt_q   <= '0;
      wr_cnt_q    <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_xfer) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (out_free) begin
            if (row_upd) begin
              row_valid_q[set_q] <= 1'b1;
            end
            miss_cnt_q <= miss_cnt_d;
            hit_cnt_q  <= hit_cnt_d;
            wr_cnt_q   <= wr_cnt_d;
            m_valid_q  <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      set_q  <= set_idx;
      tag_q  <= tag_in;
      func_q <= s_axis_tuser;
    end
    if (commit) begin
      m_hit_q  <= hit;
      m_data_q <= {32'(miss_cnt_d), 32'(hit_cnt_d), 32'(wr_cnt_d), 32'(miss_cnt_d)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_hit_q;
  assign m_axis_tdata  = m_data_q;

endmodule
